// ===== src/one_shot_alarm_timer_bank_unit_defines.svh =====
`ifndef ONE_SHOT_ALARM_TIMER_BANK_UNIT_DEFINES_SVH
`define ONE_SHOT_ALARM_TIMER_BANK_UNIT_DEFINES_SVH

// same-cycle implication
`define OSATB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSATB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/osatb_pkg.sv =====
package osatb_pkg;

    localparam int NUM_TIMERS = 4;
    localparam int SEL_W      = 2;
    localparam int OP_W       = 3;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    localparam logic [COUNT_W-1:0] PERIOD_RESET [NUM_TIMERS] =
        '{16'd10, 16'd26, 16'd100, 16'd500};

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SEL_W-1:0] timer_select;
    } cmd_t;

    typedef struct packed {
        logic                  selected_expired;
        logic [NUM_TIMERS-1:0] expired_mask;
        logic [SEL_W-1:0]      started_id;
    } rsp_t;

endpackage

// ===== src/osatb_bank.sv =====
`include "one_shot_alarm_timer_bank_unit_defines.svh"

module osatb_bank (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  osatb_pkg::cmd_t                  cmd,
    input  logic                             cfg_we,
    input  logic [osatb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [osatb_pkg::COUNT_W-1:0]    cfg_data,
    output osatb_pkg::rsp_t                  rsp
);

    logic [osatb_pkg::COUNT_W-1:0] period_reg [osatb_pkg::NUM_TIMERS];
    logic [osatb_pkg::COUNT_W-1:0] period_next [osatb_pkg::NUM_TIMERS];
    logic [osatb_pkg::COUNT_W-1:0] count_reg [osatb_pkg::NUM_TIMERS];
    logic [osatb_pkg::COUNT_W-1:0] count_next [osatb_pkg::NUM_TIMERS];
    logic [osatb_pkg::COUNT_W:0]   count_inc [osatb_pkg::NUM_TIMERS];
    logic [osatb_pkg::NUM_TIMERS-1:0] armed_reg;
    logic [osatb_pkg::NUM_TIMERS-1:0] armed_next;
    logic [osatb_pkg::NUM_TIMERS-1:0] expired_reg;
    logic [osatb_pkg::NUM_TIMERS-1:0] expired_next;
    logic [osatb_pkg::SEL_W-1:0]      sel;

    assign sel = cmd.timer_select;

    always_comb
    begin
        for (int i = 0; i < osatb_pkg::NUM_TIMERS; i++)
        begin
            period_next[i] = period_reg[i];
        end
        if (cfg_we && (cfg_index < osatb_pkg::CFG_IDX_W'(osatb_pkg::NUM_TIMERS)))
        begin
            period_next[cfg_index[osatb_pkg::SEL_W-1:0]] = cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < osatb_pkg::NUM_TIMERS; i++)
        begin
            count_inc[i]  = {1'b0, count_reg[i]} + 1'b1;
            count_next[i] = count_reg[i];
        end
        armed_next   = armed_reg;
        expired_next = expired_reg;
        if (fire)
        begin
            case (cmd.operation)
                osatb_pkg::OP_TICK:
                begin
                    for (int i = 0; i < osatb_pkg::NUM_TIMERS; i++)
                    begin
                        if (!armed_reg[i])
                        begin
                            count_next[i] = '0;
                        end
                        else if (count_inc[i] >= {1'b0, period_reg[i]})
                        begin
                            count_next[i]   = '0;
                            expired_next[i] = 1'b1;
                            armed_next[i]   = 1'b0;
                        end
                        else
                        begin
                            count_next[i] = count_inc[i][osatb_pkg::COUNT_W-1:0];
                        end
                    end
                end
                osatb_pkg::OP_START:
                begin
                    count_next[sel]   = '0;
                    expired_next[sel] = 1'b0;
                    armed_next[sel]   = 1'b1;
                end
                osatb_pkg::OP_CANCEL:
                begin
                    count_next[sel]   = '0;
                    expired_next[sel] = 1'b0;
                    armed_next[sel]   = 1'b0;
                end
                osatb_pkg::OP_CLEAR:
                begin
                    expired_next[sel] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rsp.selected_expired = expired_next[sel];
    assign rsp.expired_mask     = expired_next;
    assign rsp.started_id       = (cmd.operation == osatb_pkg::OP_START) ? sel : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < osatb_pkg::NUM_TIMERS; i++)
            begin
                period_reg[i] <= osatb_pkg::PERIOD_RESET[i];
                count_reg[i]  <= '0;
            end
            armed_reg   <= '0;
            expired_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < osatb_pkg::NUM_TIMERS; i++)
            begin
                period_reg[i] <= period_next[i];
                count_reg[i]  <= count_next[i];
            end
            armed_reg   <= armed_next;
            expired_reg <= expired_next;
        end
    end

    `OSATB_ASSERT_NOW(a_armed_not_expired, clk, rst_n, 1'b1, (armed_reg & expired_reg) == '0, "timer armed and expired")

    `OSATB_ASSERT_NEXT(a_start_arms, clk, rst_n, fire && (cmd.operation == osatb_pkg::OP_START), armed_reg[$past(sel)] && !expired_reg[$past(sel)], "start did not arm timer")

    `OSATB_ASSERT_NEXT(a_idle_holds, clk, rst_n, !fire && !cfg_we, $stable(armed_reg) && $stable(expired_reg), "timer state moved without a beat")

    for (genvar g = 0; g < osatb_pkg::NUM_TIMERS; g++)
    begin : g_chk
        `OSATB_ASSERT_NOW(a_disarmed_zero, clk, rst_n, !armed_reg[g], count_reg[g] == '0, "disarmed timer holds a count")
    end

endmodule

// ===== src/one_shot_alarm_timer_bank_unit.sv =====
// Command and response beats are registered; four timers compare and advance in parallel.
// Throughput: one command beat per cycle while the output register is not stalled.
// The input register drains whenever the output register is empty or being taken.
// Reset (rst_n, async, active low): periods return to 10, 26, 100, 500; counts, arm and
// expired flags clear; both beat registers empty.
module one_shot_alarm_timer_bank_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  osatb_pkg::cmd_t                  cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output osatb_pkg::rsp_t                  rsp,
    input  logic                             cfg_we,
    input  logic [osatb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [osatb_pkg::COUNT_W-1:0]    cfg_data
);

    logic            cmd_valid_reg;
    logic            cmd_valid_next;
    osatb_pkg::cmd_t cmd_reg;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    osatb_pkg::rsp_t rsp_reg;
    osatb_pkg::rsp_t bank_rsp;
    logic            advance;
    logic            accept;

    assign advance   = cmd_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = cmd_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    assign cmd_valid_next = accept ? 1'b1 : (advance ? 1'b0 : cmd_valid_reg);
    assign rsp_valid_next = advance ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);

    osatb_bank u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .cmd       (cmd_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (bank_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            rsp_reg <= bank_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
